>>> hw/rtl/olvt_pkg.sv
// Shared types and constants for the ordered value list table.
package olvt_pkg;

  localparam int KIND_W     = 2;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;
  localparam int POSITION_W = 4;
  localparam int COUNT_W    = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_SEARCH = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_SHIFT,
    ST_RESULT
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;        // capture the key, clear the result flags
    logic insert;      // write the key at a new head, count up
    logic ovf;         // mark a dropped insert
    logic scan_start;  // read the head entry
    logic advance;     // read the next entry, step the walk indexes
    logic hit;         // record a match at the entry under compare
    logic shift_wr;    // write the entry under compare one place toward the head
    logic dec;         // count down
    logic out_load;    // load the result register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic full;
    logic empty;
    logic match;       // entry under compare equals the key
    logic last;        // entry under compare is the last valid one
  } sts_t;

endpackage

>>> hw/rtl/olvt_ram.sv
// Generic single write, single read RAM with registered read data.
module olvt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/olvt_datapath.sv
// Datapath: circular entry store, walk indexes, compare and result register.
module olvt_datapath #(
  parameter int LIST_DEPTH  = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  olvt_pkg::cmd_t                       cmd,
  output olvt_pkg::sts_t                       sts,
  input  logic [olvt_pkg::IN_DATA_W-1:0]       in_value,
  output logic                                 res_found,
  output logic [olvt_pkg::POSITION_W-1:0]      res_position,
  output logic [olvt_pkg::COUNT_W-1:0]         res_entry_count,
  output logic                                 res_overflow
);

  localparam int IDX_W = $clog2(LIST_DEPTH);
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);

  // Logical place from the head to a physical RAM address
  function automatic logic [IDX_W-1:0] to_phys(input logic [IDX_W-1:0] base,
                                               input logic [CNT_W-1:0] ofs);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - IDX_W){1'b0}}, base} + {1'b0, ofs};
    if (sum >= (CNT_W + 1)'(LIST_DEPTH)) begin
      sum = sum - (CNT_W + 1)'(LIST_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  logic [IDX_W-1:0]       head_r, head_nxt, head_dec;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [CNT_W-1:0]       issue_idx_r, issue_idx_nxt;
  logic [CNT_W-1:0]       chk_idx_r, chk_idx_nxt;
  logic [CNT_W-1:0]       wr_idx_r, wr_idx_nxt;
  logic [VALUE_WIDTH-1:0] key_r, key_nxt;
  logic                   found_r, found_nxt;
  logic [IDX_W-1:0]       pos_r, pos_nxt;
  logic                   ovf_r, ovf_nxt;
  logic                   out_found_r, out_found_nxt;
  logic [IDX_W-1:0]       out_pos_r, out_pos_nxt;
  logic [CNT_W-1:0]       out_cnt_r, out_cnt_nxt;
  logic                   out_ovf_r, out_ovf_nxt;

  logic [VALUE_WIDTH+olvt_pkg::IN_DATA_W-1:0] val_ext;
  logic [IDX_W+olvt_pkg::POSITION_W-1:0]      pos_ext;
  logic [CNT_W+olvt_pkg::COUNT_W-1:0]         cnt_ext;

  logic                   ram_we, ram_re;
  logic [IDX_W-1:0]       ram_waddr, ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_wdata, ram_rdata;

  assign val_ext  = {{VALUE_WIDTH{1'b0}}, in_value};
  assign head_dec = (head_r == '0) ? IDX_W'(LIST_DEPTH - 1) : head_r - 1'b1;

  assign sts.full  = (count_r == CNT_W'(LIST_DEPTH));
  assign sts.empty = (count_r == '0);
  assign sts.match = (ram_rdata == key_r);
  assign sts.last  = (({1'b0, chk_idx_r} + 1'b1) == {1'b0, count_r});

  always_comb begin
    ram_we    = cmd.insert | cmd.shift_wr;
    ram_waddr = cmd.insert ? head_dec : to_phys(head_r, wr_idx_r);
    ram_wdata = cmd.insert ? key_r : ram_rdata;
    ram_re    = cmd.scan_start | cmd.advance;
    ram_raddr = cmd.scan_start ? head_r : to_phys(head_r, issue_idx_r);
  end

  olvt_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (LIST_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    head_nxt      = head_r;
    count_nxt     = count_r;
    issue_idx_nxt = issue_idx_r;
    chk_idx_nxt   = chk_idx_r;
    wr_idx_nxt    = wr_idx_r;
    key_nxt       = key_r;
    found_nxt     = found_r;
    pos_nxt       = pos_r;
    ovf_nxt       = ovf_r;
    out_found_nxt = out_found_r;
    out_pos_nxt   = out_pos_r;
    out_cnt_nxt   = out_cnt_r;
    out_ovf_nxt   = out_ovf_r;

    if (cmd.load) begin
      key_nxt   = val_ext[VALUE_WIDTH-1:0];
      found_nxt = 1'b0;
      pos_nxt   = '0;
      ovf_nxt   = 1'b0;
    end
    if (cmd.insert) begin
      head_nxt  = head_dec;
      count_nxt = count_r + 1'b1;
      found_nxt = 1'b1;
    end
    if (cmd.ovf) begin
      ovf_nxt = 1'b1;
    end
    if (cmd.scan_start) begin
      issue_idx_nxt = CNT_W'(1);
      chk_idx_nxt   = '0;
    end
    if (cmd.advance) begin
      issue_idx_nxt = issue_idx_r + 1'b1;
      chk_idx_nxt   = issue_idx_r;
      wr_idx_nxt    = chk_idx_r;
    end
    if (cmd.hit) begin
      found_nxt = 1'b1;
      pos_nxt   = chk_idx_r[IDX_W-1:0];
    end
    if (cmd.dec) begin
      count_nxt = count_r - 1'b1;
    end
    if (cmd.out_load) begin
      out_found_nxt = found_r;
      out_pos_nxt   = pos_r;
      out_cnt_nxt   = count_r;
      out_ovf_nxt   = ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      issue_idx_r <= '0;
      chk_idx_r   <= '0;
      wr_idx_r    <= '0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      issue_idx_r <= issue_idx_nxt;
      chk_idx_r   <= chk_idx_nxt;
      wr_idx_r    <= wr_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    found_r     <= found_nxt;
    pos_r       <= pos_nxt;
    ovf_r       <= ovf_nxt;
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign pos_ext = {{olvt_pkg::POSITION_W{1'b0}}, out_pos_r};
  assign cnt_ext = {{olvt_pkg::COUNT_W{1'b0}}, out_cnt_r};

  assign res_found       = out_found_r;
  assign res_position    = pos_ext[olvt_pkg::POSITION_W-1:0];
  assign res_entry_count = cnt_ext[olvt_pkg::COUNT_W-1:0];
  assign res_overflow    = out_ovf_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(LIST_DEPTH))
    else $error("entry count beyond list depth");

  a_insert_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert |-> !sts.full)
    else $error("insert written into a full list");

  a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift_wr |-> ({1'b0, wr_idx_r} + 1'b1) < {1'b0, count_r})
    else $error("shift write outside the valid entries");

endmodule

>>> hw/rtl/olvt_ctrl.sv
// Controller: request sequencing, walk control and result handshake.
module olvt_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [olvt_pkg::KIND_W-1:0]   in_kind,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output olvt_pkg::cmd_t                cmd,
  input  olvt_pkg::sts_t                sts
);

  olvt_pkg::state_t state_r, state_nxt;
  olvt_pkg::kind_t  kind_r, kind_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == olvt_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= olvt_pkg::ST_IDLE;
      kind_r      <= olvt_pkg::KIND_INSERT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;

    unique case (state_r)
      olvt_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          kind_nxt  = olvt_pkg::kind_t'(in_kind);
          state_nxt = olvt_pkg::ST_DISPATCH;
        end
      end
      olvt_pkg::ST_DISPATCH: begin
        unique case (kind_r)
          olvt_pkg::KIND_INSERT: begin
            if (sts.full) begin
              cmd.ovf = 1'b1;
            end else begin
              cmd.insert = 1'b1;
            end
            state_nxt = olvt_pkg::ST_RESULT;
          end
          olvt_pkg::KIND_REMOVE, olvt_pkg::KIND_SEARCH: begin
            if (sts.empty) begin
              state_nxt = olvt_pkg::ST_RESULT;
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt      = olvt_pkg::ST_SCAN;
            end
          end
          default: begin
            state_nxt = olvt_pkg::ST_RESULT;
          end
        endcase
      end
      olvt_pkg::ST_SCAN: begin
        if (sts.match) begin
          cmd.hit = 1'b1;
          if (kind_r == olvt_pkg::KIND_REMOVE) begin
            // last entry matched: nothing to close up
            if (sts.last) begin
              cmd.dec   = 1'b1;
              state_nxt = olvt_pkg::ST_RESULT;
            end else begin
              cmd.advance = 1'b1;
              state_nxt   = olvt_pkg::ST_SHIFT;
            end
          end else begin
            state_nxt = olvt_pkg::ST_RESULT;
          end
        end else if (sts.last) begin
          state_nxt = olvt_pkg::ST_RESULT;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      olvt_pkg::ST_SHIFT: begin
        cmd.shift_wr = 1'b1;
        if (sts.last) begin
          cmd.dec   = 1'b1;
          state_nxt = olvt_pkg::ST_RESULT;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      olvt_pkg::ST_RESULT: begin
        // hold until the result register is free
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = olvt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = olvt_pkg::ST_IDLE;
      end
    endcase
  end

  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> state_r == olvt_pkg::ST_DISPATCH)
    else $error("accepted item not dispatched");

  a_result_issue: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == olvt_pkg::ST_RESULT && !out_valid_r)
      |=> (out_valid_r && state_r == olvt_pkg::ST_IDLE))
    else $error("result not issued to a free output register");

endmodule

>>> hw/rtl/ordered_value_list_table.sv
// Top level of the ordered value list table.
//
// Bounded list of values, newest at the head. Each input item carries a
// request kind (insert, remove, search) in in_tuser and a value in in_tdata;
// each item yields exactly one result item. Entries live in a single-port
// read, single-port write RAM used as a circular buffer, so an insert writes
// the key at a new head without a walk, while search and remove walk the
// list one entry per cycle through the RAM read port; a remove closes the
// gap by streaming the entries behind the match one place forward in the
// same walk. One item is in flight at a time; a finished result waits in
// an output register, and the next item is accepted while it waits. Values
// compare on their low VALUE_WIDTH bits. No clearing pass follows reset.
module ordered_value_list_table #(
  parameter int LIST_DEPTH  = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [olvt_pkg::IN_DATA_W-1:0]    in_tdata,   // [31:0] value
  input  logic [olvt_pkg::KIND_W-1:0]       in_tuser,   // [1:0] kind
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] found, [4:1] position, [9:5] entry_count, [10] overflow, [15:11] zero
  output logic [olvt_pkg::OUT_DATA_W-1:0]   out_tdata
);

  olvt_pkg::cmd_t                      cmd;
  olvt_pkg::sts_t                      sts;
  logic                                res_found;
  logic [olvt_pkg::POSITION_W-1:0]     res_position;
  logic [olvt_pkg::COUNT_W-1:0]        res_entry_count;
  logic                                res_overflow;

  olvt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_kind    (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  olvt_datapath #(
    .LIST_DEPTH  (LIST_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_value        (in_tdata),
    .res_found       (res_found),
    .res_position    (res_position),
    .res_entry_count (res_entry_count),
    .res_overflow    (res_overflow)
  );

  assign out_tdata = {5'b0, res_overflow, res_entry_count, res_position, res_found};

endmodule
